FILE: rtl/vnt_pkg.sv
package vnt_pkg;

  // default number of fractional bits of the fixed-point format
  localparam int unsigned FracBitsDef = 16;

  // word width of every component and matrix entry
  localparam int unsigned DataW = 32;

  // matrix store layout
  localparam int unsigned PosEntries = 16;
  localparam int unsigned NrmBase    = 16;
  localparam int unsigned NrmEntries = 9;

  // item kinds
  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_VERTEX = 2'd1,
    MODE_NORMAL = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

endpackage

FILE: rtl/vertex_normal_transform.sv
// A result word passes through 5 product/sum stages, 32 square root stages,
// 1 setup stage, 32 divide stages and 1 output register. Throughput: one
// word per cycle; every stage is a register of the shared pipeline, which
// advances unless the output is stalled. Reset clears all valid bits; the
// matrix store stays undefined.
module vertex_normal_transform #(
  parameter int unsigned FRAC_BITS = vnt_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         mode_i,
  input  logic [4:0]                         entry_index_i,
  input  logic signed [vnt_pkg::DataW-1:0]   entry_value_i,
  input  logic signed [vnt_pkg::DataW-1:0]   in_x_i,
  input  logic signed [vnt_pkg::DataW-1:0]   in_y_i,
  input  logic signed [vnt_pkg::DataW-1:0]   in_z_i,
  input  logic signed [vnt_pkg::DataW-1:0]   in_w_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [vnt_pkg::DataW-1:0]   out_x_o,
  output logic signed [vnt_pkg::DataW-1:0]   out_y_o,
  output logic signed [vnt_pkg::DataW-1:0]   out_z_o,
  output logic signed [vnt_pkg::DataW-1:0]   out_w_o,
  output logic                               div_fault_o
);
  import vnt_pkg::*;

  localparam int unsigned NumW      = DataW + FRAC_BITS;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 32;

  typedef struct packed {
    logic                       norm;
    logic [3:0][DataW-1:0]      c;
  } side_t;

  typedef struct packed {
    logic [DataW-1:0] den;
    logic             zero;
    logic             fault;
    logic [DataW-1:0] w;
  } dside_t;

  // saturate a wide signed value to one word
  function automatic logic signed [DataW-1:0] sat66(input logic signed [65:0] v);
    logic signed [DataW-1:0] r;
    if (!v[65] && (|v[64:DataW-1])) r = {1'b0, {(DataW-1){1'b1}}};
    else if (v[65] && !(&v[64:DataW-1])) r = {1'b1, {(DataW-1){1'b0}}};
    else r = v[DataW-1:0];
    return r;
  endfunction

  // sign, overflow and saturation of a quotient magnitude
  function automatic logic [DataW-1:0] fin(input logic [DataW-1:0] q, input logic neg,
                                           input logic ovf);
    logic [DataW-1:0] r;
    if (ovf) r = neg ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    else if (neg) r = (q > {1'b1, {(DataW-1){1'b0}}}) ? {1'b1, {(DataW-1){1'b0}}} : -q;
    else r = q[DataW-1] ? {1'b0, {(DataW-1){1'b1}}} : q;
    return r;
  endfunction

  // handshake
  logic  adv, accept, out_valid_q;
  mode_e mode_in;
  assign mode_in    = mode_e'(mode_i);
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // matrix store
  logic signed [DataW-1:0] pos_q [PosEntries];
  logic signed [DataW-1:0] nrm_q [NrmEntries];
  logic [3:0]              nrm_idx;
  assign nrm_idx = 4'(entry_index_i - 5'(NrmBase));

  always_ff @(posedge clk_i) begin
    if (accept && mode_in == MODE_LOAD) begin
      if (entry_index_i < 5'(NrmBase)) begin
        pos_q[entry_index_i[3:0]] <= entry_value_i;
      end else if (entry_index_i < 5'(NrmBase + NrmEntries)) begin
        nrm_q[nrm_idx] <= entry_value_i;
      end
    end
  end

  // coefficient selection for the product stage
  logic signed [DataW-1:0] coef [4][4];
  logic signed [DataW-1:0] vec  [4];
  always_comb begin
    vec[0] = in_x_i;
    vec[1] = in_y_i;
    vec[2] = in_z_i;
    vec[3] = in_w_i;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (mode_in == MODE_NORMAL) begin
          coef[r][c] = (r < 3 && c < 3) ? nrm_q[(r * 3 + c) % NrmEntries] : '0;
        end else begin
          coef[r][c] = pos_q[r * 4 + c];
        end
      end
    end
  end

  // stage registers
  logic                     s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic                     s1_norm_q, s2_norm_q, s3_norm_q, s4_norm_q;
  logic signed [63:0]       prod_q [4][4];
  logic signed [64:0]       psum_q [4][2];
  logic signed [DataW-1:0]  c3_q [4];
  logic signed [DataW-1:0]  c4_q [4];
  logic [63:0]              sq_q [3];

  // row sums, floor shift, saturation
  logic signed [65:0] tot [4];
  logic signed [65:0] shr [4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      tot[r] = 66'(psum_q[r][0]) + 66'(psum_q[r][1]);
      shr[r] = tot[r] >>> FRAC_BITS;
    end
  end

  // square root pipeline, index 0 is the sum of squares stage
  logic               sv_q      [SqrtSteps+1];
  side_t              sd_q      [SqrtSteps+1];
  logic [63:0]        sq_rad_q  [SqrtSteps+1];
  logic [33:0]        sq_rem_q  [SqrtSteps+1];
  logic [DataW-1:0]   sq_root_q [SqrtSteps+1];
  logic [63:0]        sq_rad_d  [SqrtSteps];
  logic [33:0]        sq_rem_d  [SqrtSteps];
  logic [DataW-1:0]   sq_root_d [SqrtSteps];
  logic [35:0]        rem_sh    [SqrtSteps];
  logic [35:0]        trial     [SqrtSteps];
  side_t              s5_side;

  always_comb begin
    s5_side.norm = s4_norm_q;
    for (int i = 0; i < 4; i++) s5_side.c[i] = c4_q[i];
    for (int k = 0; k < SqrtSteps; k++) begin
      rem_sh[k]   = {sq_rem_q[k], sq_rad_q[k][63:62]};
      trial[k]    = {2'b00, sq_root_q[k], 2'b01};
      sq_rad_d[k] = {sq_rad_q[k][61:0], 2'b00};
      if (rem_sh[k] >= trial[k]) begin
        sq_rem_d[k]  = 34'(rem_sh[k] - trial[k]);
        sq_root_d[k] = {sq_root_q[k][DataW-2:0], 1'b1};
      end else begin
        sq_rem_d[k]  = rem_sh[k][33:0];
        sq_root_d[k] = {sq_root_q[k][DataW-2:0], 1'b0};
      end
    end
  end

  // divider setup from the root and the clip-space w
  side_t              sqs;
  logic [DataW-1:0]   den_s;
  logic [DataW-1:0]   absc [3];
  logic [NumW-1:0]    absnum [3];
  logic               neg_s [3];
  logic               ovf_s [3];
  dside_t             dside_s;

  always_comb begin
    sqs   = sd_q[SqrtSteps];
    den_s = sqs.norm ? sq_root_q[SqrtSteps]
                     : (sqs.c[3][DataW-1] ? -sqs.c[3] : sqs.c[3]);
    for (int i = 0; i < 3; i++) begin
      absc[i]   = sqs.c[i][DataW-1] ? -sqs.c[i] : sqs.c[i];
      absnum[i] = {absc[i], {FRAC_BITS{1'b0}}};
      neg_s[i]  = sqs.c[i][DataW-1] ^ (!sqs.norm && sqs.c[3][DataW-1]);
      ovf_s[i]  = DataW'(absnum[i][NumW-1:DataW]) >= den_s;
    end
    dside_s.den   = den_s;
    dside_s.zero  = (den_s == '0);
    dside_s.fault = !sqs.norm && (sqs.c[3] == '0);
    dside_s.w     = sqs.norm ? '0 : sqs.c[3];
  end

  // divide pipeline, index 0 is the setup stage
  logic               dvv_q     [DivSteps+1];
  dside_t             dd_q      [DivSteps+1];
  logic [DataW-1:0]   dv_rem_q  [DivSteps+1][3];
  logic [DataW-1:0]   dv_low_q  [DivSteps+1][3];
  logic [DataW-1:0]   dv_quo_q  [DivSteps+1][3];
  logic               dv_neg_q  [DivSteps+1][3];
  logic               dv_ovf_q  [DivSteps+1][3];
  logic [DataW-1:0]   dv_rem_d  [DivSteps][3];
  logic [DataW-1:0]   dv_quo_d  [DivSteps][3];
  logic [DataW:0]     dv_sh     [DivSteps][3];

  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      for (int i = 0; i < 3; i++) begin
        dv_sh[k][i] = {dv_rem_q[k][i], dv_low_q[k][i][DataW-1]};
        if (dv_sh[k][i] >= {1'b0, dd_q[k].den}) begin
          dv_rem_d[k][i] = DataW'(dv_sh[k][i] - {1'b0, dd_q[k].den});
          dv_quo_d[k][i] = {dv_quo_q[k][i][DataW-2:0], 1'b1};
        end else begin
          dv_rem_d[k][i] = dv_sh[k][i][DataW-1:0];
          dv_quo_d[k][i] = {dv_quo_q[k][i][DataW-2:0], 1'b0};
        end
      end
    end
  end

  // output word
  dside_t             dfin;
  logic [DataW-1:0]   res_d [3];
  always_comb begin
    dfin = dd_q[DivSteps];
    for (int i = 0; i < 3; i++) begin
      res_d[i] = dfin.zero ? '0 : fin(dv_quo_q[DivSteps][i], dv_neg_q[DivSteps][i],
                                      dv_ovf_q[DivSteps][i]);
    end
  end

  logic signed [DataW-1:0] out_x_q, out_y_q, out_z_q, out_w_q;
  logic                    out_fault_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= SqrtSteps; k++) sv_q[k] <= 1'b0;
      for (int k = 0; k <= DivSteps; k++) dvv_q[k] <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept && (mode_in == MODE_VERTEX || mode_in == MODE_NORMAL);
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      sv_q[0]    <= s4_valid_q;
      for (int k = 0; k < SqrtSteps; k++) sv_q[k+1] <= sv_q[k];
      dvv_q[0]   <= sv_q[SqrtSteps];
      for (int k = 0; k < DivSteps; k++) dvv_q[k+1] <= dvv_q[k];
      out_valid_q <= dvv_q[DivSteps];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_norm_q <= (mode_in == MODE_NORMAL);
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_q[r][c] <= 64'(coef[r][c]) * 64'(vec[c]);
        end
      end
      s2_norm_q <= s1_norm_q;
      for (int r = 0; r < 4; r++) begin
        psum_q[r][0] <= 65'(prod_q[r][0]) + 65'(prod_q[r][1]);
        psum_q[r][1] <= 65'(prod_q[r][2]) + 65'(prod_q[r][3]);
      end
      s3_norm_q <= s2_norm_q;
      for (int r = 0; r < 4; r++) c3_q[r] <= sat66(shr[r]);
      s4_norm_q <= s3_norm_q;
      for (int r = 0; r < 4; r++) c4_q[r] <= c3_q[r];
      for (int i = 0; i < 3; i++) sq_q[i] <= 64'(64'(c3_q[i]) * 64'(c3_q[i]));

      sd_q[0]      <= s5_side;
      sq_rad_q[0]  <= sq_q[0] + sq_q[1] + sq_q[2];
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      for (int k = 0; k < SqrtSteps; k++) begin
        sd_q[k+1]      <= sd_q[k];
        sq_rad_q[k+1]  <= sq_rad_d[k];
        sq_rem_q[k+1]  <= sq_rem_d[k];
        sq_root_q[k+1] <= sq_root_d[k];
      end

      dd_q[0] <= dside_s;
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= DataW'(absnum[i][NumW-1:DataW]);
        dv_low_q[0][i] <= absnum[i][DataW-1:0];
        dv_quo_q[0][i] <= '0;
        dv_neg_q[0][i] <= neg_s[i];
        dv_ovf_q[0][i] <= ovf_s[i];
      end
      for (int k = 0; k < DivSteps; k++) begin
        dd_q[k+1] <= dd_q[k];
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[k+1][i] <= dv_rem_d[k][i];
          dv_low_q[k+1][i] <= {dv_low_q[k][i][DataW-2:0], 1'b0};
          dv_quo_q[k+1][i] <= dv_quo_d[k][i];
          dv_neg_q[k+1][i] <= dv_neg_q[k][i];
          dv_ovf_q[k+1][i] <= dv_ovf_q[k][i];
        end
      end

      out_x_q     <= res_d[0];
      out_y_q     <= res_d[1];
      out_z_q     <= res_d[2];
      out_w_q     <= dfin.w;
      out_fault_q <= dfin.fault;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign out_w_o     = out_w_q;
  assign div_fault_o = out_fault_q;

endmodule

FILE: test/vnt_checker.sv
`timescale 1ns / 100ps

module vnt_checker #(
  parameter int unsigned FRAC_BITS = vnt_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  mode_i,
  input  logic [4:0]  entry_index_i,
  input  logic [31:0] entry_value_i,
  input  logic [31:0] in_x_i,
  input  logic [31:0] in_y_i,
  input  logic [31:0] in_z_i,
  input  logic [31:0] in_w_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] out_x_i,
  input  logic [31:0] out_y_i,
  input  logic [31:0] out_z_i,
  input  logic [31:0] out_w_i,
  input  logic        div_fault_i,
  output int          errors_o,
  output int          pending_o
);
  import vnt_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        fault;
  } geom_word_t;

  logic signed [31:0] pos_mtx [PosEntries];
  logic signed [31:0] nrm_mtx [NrmEntries];
  geom_word_t expected_words [$];

  // clamp a wide signed value into 32 bits
  function automatic logic signed [31:0] clamp32(logic signed [67:0] v);
    if (v > 68'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -68'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // exact dot product, floor shift, clamp
  function automatic logic signed [31:0] row_dot(logic signed [31:0] a [4],
                                                 logic signed [31:0] b [4]);
    logic signed [67:0] acc;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      acc = acc + $signed(a[i]) * $signed(b[i]);
    end
    return clamp32(acc >>> FRAC_BITS);
  endfunction

  // fixed-point quotient, truncated toward zero
  function automatic logic signed [31:0] fx_quot(longint num, longint den);
    longint q;
    q = (num * (longint'(1) << FRAC_BITS)) / den;
    return clamp32(68'(q));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // predict the output word of one vertex or normal
  function automatic geom_word_t transform_word(logic [1:0] mode, logic signed [31:0] v [4]);
    geom_word_t res;
    logic signed [31:0] row [4];
    logic signed [31:0] c [4];
    logic signed [31:0] v3 [4];
    longint unsigned ss, len;
    res = '0;
    if (mode == MODE_VERTEX) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 4; k++) row[k] = pos_mtx[4*r+k];
        c[r] = row_dot(row, v);
      end
      if (c[3] == 0) begin
        res.fault = 1'b1;
      end else begin
        res.x = fx_quot(c[0], c[3]);
        res.y = fx_quot(c[1], c[3]);
        res.z = fx_quot(c[2], c[3]);
        res.w = c[3];
      end
    end else begin
      v3 = v;
      v3[3] = '0;
      ss = 0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) row[k] = nrm_mtx[3*r+k];
        row[3] = '0;
        c[r] = row_dot(row, v3);
        ss = ss + longint'(c[r]) * longint'(c[r]);
      end
      len = int_sqrt(ss);
      if (len != 0) begin
        res.x = fx_quot(c[0], longint'(len));
        res.y = fx_quot(c[1], longint'(len));
        res.z = fx_quot(c[2], longint'(len));
      end
    end
    return res;
  endfunction

  assign pending_o = expected_words.size();

  // track accepted input words and predict
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] v [4];
    if (!rst_ni) begin
      expected_words.delete();
    end else if (in_valid_i && !in_stall_i) begin
      v[0] = in_x_i;
      v[1] = in_y_i;
      v[2] = in_z_i;
      v[3] = in_w_i;
      case (mode_i)
        MODE_LOAD: begin
          if (entry_index_i < NrmBase) pos_mtx[entry_index_i[3:0]] = entry_value_i;
          else if (entry_index_i < NrmBase + NrmEntries)
            nrm_mtx[4'(entry_index_i - 5'(NrmBase))] = entry_value_i;
        end
        MODE_VERTEX, MODE_NORMAL: begin
          expected_words.push_back(transform_word(mode_i, v));
        end
        default: ;
      endcase
    end
  end

  // compare accepted output words
  always @(posedge clk_i or negedge rst_ni) begin
    geom_word_t got, want;
    if (!rst_ni) begin
      errors_o <= 0;
    end else if (out_valid_i && !out_stall_i) begin
      got = {out_x_i, out_y_i, out_z_i, out_w_i, div_fault_i};
      if (expected_words.size() == 0) begin
        if (errors_o < 10) $display("unexpected output word %h", got);
        errors_o <= errors_o + 1;
      end else begin
        want = expected_words.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.w !== want.w || got.fault !== want.fault) begin
          if (errors_o < 10) begin
            $display("mismatch: x %h/%h y %h/%h z %h/%h w %h/%h fault %b/%b (exp/act)",
                     want.x, got.x, want.y, got.y, want.z, got.z, want.w, got.w,
                     want.fault, got.fault);
          end
          errors_o <= errors_o + 1;
        end
      end
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import vnt_pkg::*;

  localparam int StallLimit = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0;
  logic [4:0]  entry_index_i = '0;
  logic signed [31:0] entry_value_i = '0;
  logic signed [31:0] in_x_i = '0, in_y_i = '0, in_z_i = '0, in_w_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [31:0] out_x_o, out_y_o, out_z_o, out_w_o;
  logic        div_fault_o;
  int          errors, pending;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;
  int          idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  vertex_normal_transform dut (.*);

  vnt_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .entry_index_i,
    .entry_value_i, .in_x_i, .in_y_i, .in_z_i, .in_w_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_x_i(out_x_o), .out_y_i(out_y_o),
    .out_z_i(out_z_o), .out_w_i(out_w_o), .div_fault_i(div_fault_o),
    .errors_o(errors), .pending_o(pending)
  );

  // mixed-magnitude fixed-point value
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3:       return '0;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  // offer one word and hold it until accepted
  task automatic send_word(logic [1:0] mode, logic [4:0] idx, logic [31:0] val,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    entry_index_i <= idx;
    entry_value_i <= val;
    in_x_i        <= x;
    in_y_i        <= y;
    in_z_i        <= z;
    in_w_i        <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random_vector(logic [1:0] mode);
    send_word(mode, 5'($urandom()), $urandom(), pick_value(), pick_value(), pick_value(),
              pick_value());
  endtask

  // receiver: random stall per word, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      n = calm ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("vertex_normal_transform regression: fail");
      $finish;
    end
  end

  initial begin
    int sel;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity matrices, scaled by one in Q16.16
    for (int i = 0; i < PosEntries; i++) begin
      send_word(MODE_LOAD, 5'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'h0, 0, 0, 0, 0);
    end
    for (int i = 0; i < NrmEntries; i++) begin
      send_word(MODE_LOAD, 5'(NrmBase + i), (i % 4 == 0) ? 32'h0001_0000 : 32'h0,
                0, 0, 0, 0);
    end
    // zero w gives a fault, plain vertex, extremes
    send_word(MODE_VERTEX, 0, 0, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 32'h0);
    send_word(MODE_VERTEX, 0, 0, 32'h0002_0000, 32'hFFFD_0000, 32'h0001_0000, 32'h0002_0000);
    send_word(MODE_VERTEX, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    send_word(MODE_VERTEX, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    // zero-length normal, ordinary and extreme normals
    send_word(MODE_NORMAL, 0, 0, 32'h0, 32'h0, 32'h0, 32'h1234_5678);
    send_word(MODE_NORMAL, 0, 0, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
    send_word(MODE_NORMAL, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    // ignored words
    send_word(MODE_NONE, 5, 32'hDEAD_BEEF, 32'h1, 32'h1, 32'h1, 32'h1);
    send_word(MODE_LOAD, 25, 32'h7FFF_FFFF, 0, 0, 0, 0);
    send_word(MODE_LOAD, 31, 32'h8000_0000, 0, 0, 0, 0);
    // extreme matrix entries
    send_word(MODE_LOAD, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
    send_word(MODE_LOAD, 17, 32'h8000_0000, 0, 0, 0, 0);
    send_word(MODE_VERTEX, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(MODE_NORMAL, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0);

    // random traffic
    for (int n = 0; n < 1550; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 500) hold_off = 1'b1;
      if (n == 1000) begin
        in_valid_i <= 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
      sel = $urandom_range(0, 99);
      if (sel < 20) send_word(MODE_LOAD, 5'($urandom()), pick_value(), $urandom(),
                              $urandom(), $urandom(), $urandom());
      else if (sel < 60) send_random_vector(MODE_VERTEX);
      else if (sel < 95) send_random_vector(MODE_NORMAL);
      else send_random_vector(MODE_NONE);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("vertex_normal_transform regression: pass");
    end else begin
      $display("vertex_normal_transform regression: fail");
    end
    $finish;
  end

endmodule
